/* sv/sads_pkg.sv */
package sads_pkg;

   // fixed widths of the transfer fields
   localparam int IN_BITS     = 32;
   localparam int STATUS_BITS = 2;

   // defaults for the top-level parameters
   localparam int DEFAULT_DEPTH     = 128;
   localparam int DEFAULT_WORD_BITS = 32;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_POP  = 1'b1
   } action_type;

   typedef enum logic {
      SEL_FIRST  = 1'b0,
      SEL_SECOND = 1'b1
   } select_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch the request fields
      logic execute;   // apply push or pop, write or read the store
      logic capture;   // move store read data into the result register
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_pop;
      logic refused;
   } dp_stat_type;

endpackage

/* sv/sads_if.sv */
interface sads_req_if;
   logic                                valid;
   logic                                ready;
   logic                                action;
   logic                                stack_select;
   logic signed [sads_pkg::IN_BITS-1:0] push_value;

   modport source (output valid, action, stack_select, push_value, input ready);
   modport sink   (input valid, action, stack_select, push_value, output ready);
endinterface

interface sads_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [sads_pkg::IN_BITS-1:0]     pop_value;
   logic        [sads_pkg::STATUS_BITS-1:0] status;
   logic                                    store_full;
   logic                                    first_empty;
   logic                                    second_empty;

   modport source (output valid, pop_value, status, store_full, first_empty, second_empty,
                   input ready);
   modport sink   (input valid, pop_value, status, store_full, first_empty, second_empty,
                   output ready);
endinterface

/* sv/sads_ctrl.sv */
module sads_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sads_pkg::dp_stat_type stat,
   output sads_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_READ = 4'b0100,
      S_RESP = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            if (stat.is_pop && !stat.refused) state_in = S_READ;
            else                              state_in = S_RESP;
         end
         S_READ: begin
            cmd.capture = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

/* sv/sads_dp.sv */
module sads_dp #(
   parameter int DEPTH     = sads_pkg::DEFAULT_DEPTH,
   parameter int WORD_BITS = sads_pkg::DEFAULT_WORD_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  sads_pkg::dp_cmd_type                    cmd,
   output sads_pkg::dp_stat_type                   stat,
   input  logic                                    req_action,
   input  logic                                    req_stack_select,
   input  logic signed [sads_pkg::IN_BITS-1:0]     req_push_value,
   output logic signed [sads_pkg::IN_BITS-1:0]     rsp_pop_value,
   output logic        [sads_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                                    rsp_store_full,
   output logic                                    rsp_first_empty,
   output logic                                    rsp_second_empty
);

   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] mem [DEPTH];

   logic                                action_ff;
   logic                                select_ff;
   logic signed [sads_pkg::IN_BITS-1:0] push_ff;
   logic [CNT_BITS-1:0]                 first_cnt_ff, first_cnt_in;
   logic [CNT_BITS-1:0]                 second_cnt_ff, second_cnt_in;
   logic [WORD_BITS-1:0]                rd_data_ff;
   logic signed [sads_pkg::IN_BITS-1:0] value_ff;
   sads_pkg::status_type                status_ff;

   logic                 full;
   logic                 first_empty;
   logic                 second_empty;
   logic                 refused;
   logic                 wr_en;
   logic                 rd_en;
   logic [ADDR_BITS-1:0] waddr;
   logic [ADDR_BITS-1:0] raddr;
   logic [CNT_BITS-1:0]  second_top;
   logic [WORD_BITS-1:0] wdata;

   assign full         = ({1'b0, first_cnt_ff} + {1'b0, second_cnt_ff})
                         == (CNT_BITS + 1)'(DEPTH);
   assign first_empty  = (first_cnt_ff == '0);
   assign second_empty = (second_cnt_ff == '0);

   always_comb begin
      if (action_ff == sads_pkg::ACT_PUSH)      refused = full;
      else if (select_ff == sads_pkg::SEL_FIRST) refused = first_empty;
      else                                       refused = second_empty;
   end

   assign stat.is_pop  = (action_ff == sads_pkg::ACT_POP);
   assign stat.refused = refused;

   assign wr_en = cmd.execute && !refused && (action_ff == sads_pkg::ACT_PUSH);
   assign rd_en = cmd.execute && !refused && (action_ff == sads_pkg::ACT_POP);

   // second stack top entry, read by a pop: DEPTH - count
   assign second_top = CNT_BITS'(DEPTH) - second_cnt_ff;

   always_comb begin
      if (select_ff == sads_pkg::SEL_FIRST) begin
         waddr = first_cnt_ff[ADDR_BITS-1:0];
         raddr = ADDR_BITS'(first_cnt_ff - CNT_BITS'(1));
      end else begin
         waddr = ADDR_BITS'(DEPTH - 1) - second_cnt_ff[ADDR_BITS-1:0];
         raddr = second_top[ADDR_BITS-1:0];
      end
   end

   // sign-extend or truncate the pushed word to the store width
   assign wdata = WORD_BITS'(push_ff);

   always_comb begin
      first_cnt_in  = first_cnt_ff;
      second_cnt_in = second_cnt_ff;
      if (cmd.execute && !refused) begin
         if (action_ff == sads_pkg::ACT_PUSH) begin
            if (select_ff == sads_pkg::SEL_FIRST) first_cnt_in  = first_cnt_ff + CNT_BITS'(1);
            else                                  second_cnt_in = second_cnt_ff + CNT_BITS'(1);
         end else begin
            if (select_ff == sads_pkg::SEL_FIRST) first_cnt_in  = first_cnt_ff - CNT_BITS'(1);
            else                                  second_cnt_in = second_cnt_ff - CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_cnt_ff  <= '0;
         second_cnt_ff <= '0;
      end else begin
         first_cnt_ff  <= first_cnt_in;
         second_cnt_ff <= second_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      if (rd_en) rd_data_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         select_ff <= req_stack_select;
         push_ff   <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (action_ff == sads_pkg::ACT_PUSH) begin
            value_ff  <= '0;
            status_ff <= refused ? sads_pkg::ST_FULL : sads_pkg::ST_OK;
         end else begin
            value_ff  <= '1;
            status_ff <= refused ? sads_pkg::ST_EMPTY : sads_pkg::ST_OK;
         end
      end else if (cmd.capture) begin
         value_ff <= sads_pkg::IN_BITS'(rd_data_ff);
      end
   end

   assign rsp_pop_value    = value_ff;
   assign rsp_status       = status_ff;
   assign rsp_store_full   = full;
   assign rsp_first_empty  = first_empty;
   assign rsp_second_empty = second_empty;

endmodule

/* sv/shared_array_double_stack_core.sv */
// channel   dir  handshake    payload
// req_chan  in   valid/ready  action, stack_select, push_value
// rsp_chan  out  valid/ready  pop_value, status, store_full, first_empty, second_empty
//
// a push runs through the execute state and an accepted pop through the execute and store read states
// before the result state, where rsp valid rises; a refused pop skips the store read; the order is
// set by the controller states and the registered read port of the store
// one request at a time: req ready is high only while the block is idle and out of reset
// reset clears both stack counts; store contents are not cleared
// a stalled rsp holds its payload and keeps req ready low until the transfer
module shared_array_double_stack_core #(
   parameter int DEPTH     = sads_pkg::DEFAULT_DEPTH,
   parameter int WORD_BITS = sads_pkg::DEFAULT_WORD_BITS
) (
   input  logic              clock,
   input  logic              reset,
   sads_req_if.sink          req_chan,
   sads_rsp_if.source        rsp_chan
);

   // command and status between controller and datapath
   sads_pkg::dp_cmd_type  cmd;
   sads_pkg::dp_stat_type stat;

   // sequencer: idle, execute, store read, result
   sads_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // counts, shared store and result registers
   sads_dp #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_stack_select (req_chan.stack_select),
      .req_push_value   (req_chan.push_value),
      .rsp_pop_value    (rsp_chan.pop_value),
      .rsp_status       (rsp_chan.status),
      .rsp_store_full   (rsp_chan.store_full),
      .rsp_first_empty  (rsp_chan.first_empty),
      .rsp_second_empty (rsp_chan.second_empty)
   );

endmodule
